FILE: rtl/vvsc_pkg.sv
// Package for the vector configuration unit: beat types, the decoded
// command passed from front end to back end, and the vlmul decode function.
// No dependencies.
`default_nettype none

package vvsc_pkg;

  // Instruction kinds on the input channel
  localparam logic [1:0] KIND_VSETVL   = 2'd0;
  localparam logic [1:0] KIND_VSETVLI  = 2'd1;
  localparam logic [1:0] KIND_VSETIVLI = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  // Configuration register indexes
  localparam logic REG_XLEN_64 = 1'b0;

  // Depth of the queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  localparam int VL_W   = 8;
  localparam int LMUL_W = 7;
  localparam int SEW_W  = 11;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] vtype_value;
    logic [63:0] avl_value;
    logic        rs1_is_zero;
    logic        rd_is_zero;
  } in_data_t;

  typedef struct packed {
    logic              rd_write;
    logic [VL_W-1:0]   rd_value;
    logic [VL_W-1:0]   new_vl;
    logic [LMUL_W-1:0] lmul_eighths;
    logic [SEW_W-1:0]  sew_bits;
    logic              tail_agnostic;
    logic              mask_agnostic;
    logic              bad_vtype;
  } out_data_t;

  // What the back end does with a command
  typedef enum logic [2:0] {
    OP_IGNORE = 3'd0,  // unused kind: report state only
    OP_BAD    = 3'd1,  // reserved vlmul: report state and error
    OP_AVL    = 3'd2,  // vl = min(VLMAX, avl)
    OP_MAX    = 3'd3,  // vl = VLMAX
    OP_KEEP   = 3'd4   // vl unchanged, vtype updated
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [VL_W-1:0]   vl_cand;
    logic [LMUL_W-1:0] lmul_eighths;
    logic [SEW_W-1:0]  sew_bits;
    logic              vta;
    logic              vma;
    logic              rd_write;
  } cmd_t;

  typedef struct packed {
    logic       bad;
    logic [2:0] log2_eighths;
  } lmul_dec_t;

  // Map vlmul to log2 of LMUL in eighths; encoding 100 is reserved
  function automatic lmul_dec_t lmul_decode(input logic [2:0] vlmul);
    lmul_dec_t d;
    d.bad = 1'b0;
    case (vlmul)
      3'b000:  d.log2_eighths = 3'd3;
      3'b001:  d.log2_eighths = 3'd4;
      3'b010:  d.log2_eighths = 3'd5;
      3'b011:  d.log2_eighths = 3'd6;
      3'b101:  d.log2_eighths = 3'd0;
      3'b110:  d.log2_eighths = 3'd1;
      3'b111:  d.log2_eighths = 3'd2;
      default: begin
        d.bad          = 1'b1;
        d.log2_eighths = 3'd0;
      end
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/vvsc_front.sv
// Front end of the vector configuration unit: masks operands, decodes vtype,
// works out VLMAX and classifies the instruction. Depends on vvsc_pkg.
`default_nettype none

module vvsc_front #(
  parameter int VLEN_BITS = 128
) (
  input  wire                 xlen_64,
  input  vvsc_pkg::in_data_t  in_data,
  output vvsc_pkg::cmd_t      cmd
);

  // VLEN * 64 fits in this width
  localparam int VLMAX_W = $clog2(VLEN_BITS + 1) + 6;

  logic [63:0]            vtype_m;
  logic [63:0]            avl_m;
  vvsc_pkg::lmul_dec_t    dec;
  logic [2:0]             vsew;
  logic [VLMAX_W-1:0]     prod;
  logic [VLMAX_W-1:0]     vlmax;
  logic                   avl_below;
  logic [vvsc_pkg::VL_W-1:0] vl_min;
  vvsc_pkg::op_t          op;

  // Drop the upper word in RV32 mode
  assign vtype_m = xlen_64 ? in_data.vtype_value : {32'd0, in_data.vtype_value[31:0]};
  assign avl_m   = xlen_64 ? in_data.avl_value   : {32'd0, in_data.avl_value[31:0]};

  assign dec  = vvsc_pkg::lmul_decode(vtype_m[2:0]);
  assign vsew = vtype_m[5:3];

  // VLMAX = VLEN * lmul_eighths / (8 * SEW), all powers of two but VLEN
  assign prod  = VLMAX_W'(VLEN_BITS) << dec.log2_eighths;
  assign vlmax = prod >> (4'd6 + {1'b0, vsew});

  assign avl_below = avl_m < 64'(vlmax);
  assign vl_min    = avl_below ? avl_m[vvsc_pkg::VL_W-1:0] : vlmax[vvsc_pkg::VL_W-1:0];

  // Classify the instruction
  always_comb begin
    if (in_data.kind == vvsc_pkg::KIND_NONE) begin
      op = vvsc_pkg::OP_IGNORE;
    end else if (dec.bad) begin
      op = vvsc_pkg::OP_BAD;
    end else if (in_data.kind == vvsc_pkg::KIND_VSETIVLI || !in_data.rs1_is_zero) begin
      op = vvsc_pkg::OP_AVL;
    end else if (!in_data.rd_is_zero) begin
      op = vvsc_pkg::OP_MAX;
    end else begin
      op = vvsc_pkg::OP_KEEP;
    end
  end

  // Build the command for the back end
  always_comb begin
    cmd.op           = op;
    cmd.vl_cand      = (op == vvsc_pkg::OP_AVL) ? vl_min : vlmax[vvsc_pkg::VL_W-1:0];
    cmd.lmul_eighths = vvsc_pkg::LMUL_W'(1) << dec.log2_eighths;
    cmd.sew_bits     = vvsc_pkg::SEW_W'(8) << vsew;
    cmd.vta          = vtype_m[6];
    cmd.vma          = vtype_m[7];
    cmd.rd_write     = !in_data.rd_is_zero &&
                       (op == vvsc_pkg::OP_AVL || op == vvsc_pkg::OP_MAX ||
                        op == vvsc_pkg::OP_KEEP);
  end

endmodule

`default_nettype wire

FILE: rtl/vvsc_queue.sv
// Short command queue between front and back end of the vector configuration
// unit. Depends on vvsc_pkg.
`default_nettype none

module vvsc_queue (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  vvsc_pkg::cmd_t  push_cmd,
  output logic            not_full,
  input  wire             pop,
  output vvsc_pkg::cmd_t  head_cmd,
  output logic            not_empty
);

  localparam int PTR_W = $clog2(vvsc_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(vvsc_pkg::QUEUE_DEPTH + 1);

  vvsc_pkg::cmd_t   entry_r [vvsc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign not_full  = count_r != CNT_W'(vvsc_pkg::QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head_cmd  = entry_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(vvsc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(vvsc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !not_full))
    else $error("queue pushed while full");
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !not_empty))
    else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

FILE: rtl/vvsc_back.sv
// Back end of the vector configuration unit: holds vl and the decoded vtype,
// applies commands in order and drives the result register. Depends on vvsc_pkg.
`default_nettype none

module vvsc_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cmd_valid,
  input  vvsc_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output vvsc_pkg::out_data_t out_data
);

  logic [vvsc_pkg::VL_W-1:0]   vl_r, vl_nxt;
  logic [vvsc_pkg::LMUL_W-1:0] lmul_r, lmul_nxt;
  logic [vvsc_pkg::SEW_W-1:0]  sew_r, sew_nxt;
  logic                        vta_r, vta_nxt;
  logic                        vma_r, vma_nxt;
  logic                        out_valid_r;
  vvsc_pkg::out_data_t         out_data_r, out_data_nxt;
  logic                        bad;

  // Take a command when the result register is free or being drained
  assign cmd_pop = cmd_valid && (!out_valid_r || out_ready);

  // Apply the command to the state
  always_comb begin
    vl_nxt   = vl_r;
    lmul_nxt = lmul_r;
    sew_nxt  = sew_r;
    vta_nxt  = vta_r;
    vma_nxt  = vma_r;
    bad      = 1'b0;
    case (cmd.op)
      vvsc_pkg::OP_IGNORE: begin
      end
      vvsc_pkg::OP_BAD: begin
        bad = 1'b1;
      end
      vvsc_pkg::OP_AVL, vvsc_pkg::OP_MAX, vvsc_pkg::OP_KEEP: begin
        if (cmd.op != vvsc_pkg::OP_KEEP) begin
          vl_nxt = cmd.vl_cand;
        end
        lmul_nxt = cmd.lmul_eighths;
        sew_nxt  = cmd.sew_bits;
        vta_nxt  = cmd.vta;
        vma_nxt  = cmd.vma;
      end
      default: begin
      end
    endcase
  end

  // Form the result beat from the updated state
  always_comb begin
    out_data_nxt.rd_write      = cmd.rd_write;
    out_data_nxt.rd_value      = cmd.rd_write ? vl_nxt : '0;
    out_data_nxt.new_vl        = vl_nxt;
    out_data_nxt.lmul_eighths  = lmul_nxt;
    out_data_nxt.sew_bits      = sew_nxt;
    out_data_nxt.tail_agnostic = vta_nxt;
    out_data_nxt.mask_agnostic = vma_nxt;
    out_data_nxt.bad_vtype     = bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r        <= '0;
      lmul_r      <= vvsc_pkg::LMUL_W'(8);
      sew_r       <= vvsc_pkg::SEW_W'(8);
      vta_r       <= 1'b0;
      vma_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_pop) begin
        vl_r        <= vl_nxt;
        lmul_r      <= lmul_nxt;
        sew_r       <= sew_nxt;
        vta_r       <= vta_nxt;
        vma_r       <= vma_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_lmul_sew_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(lmul_r) && $onehot(sew_r))
    else $error("decoded lmul or sew not a power of two");
  a_bad_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.bad_vtype |-> !out_data_r.rd_write)
    else $error("reserved vtype wrote rd");
  a_vl_bad_kept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop && (cmd.op == vvsc_pkg::OP_BAD || cmd.op == vvsc_pkg::OP_IGNORE)
    |=> $stable(vl_r) && $stable(lmul_r) && $stable(sew_r))
    else $error("state changed on ignored or reserved instruction");
  a_rd_matches_vl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.rd_write |-> out_data_r.rd_value == vl_r)
    else $error("rd value differs from vl");
`endif

endmodule

`default_nettype wire

FILE: rtl/vector_vset_config_unit.sv
// Top level of the vector configuration unit (vsetvl, vsetvli, vsetivli).
// Depends on vvsc_pkg, vvsc_front, vvsc_queue and vvsc_back.
`default_nettype none

// One configuration instruction enters per beat on the in_ channel and one
// result beat leaves on the out_ channel, in order. The front end decodes and
// classifies in the cycle of acceptance and writes a two-entry queue; the
// back end applies one command per cycle while its result register is free or
// being drained, updating vl and the decoded vtype and registering the result,
// so the unit sustains one instruction per cycle while out_ready stays high.
// The sole register, xlen_64 at address 0 (reset 1), selects RV64; 0 truncates
// avl and vtype to 32 bits. Write it only while the unit is idle.
module vector_vset_config_unit #(
  parameter int VLEN_BITS = 128
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  vvsc_pkg::in_data_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output vvsc_pkg::out_data_t out_data,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [2:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic           xlen_64_r;
  logic           cfg_write;
  vvsc_pkg::cmd_t front_cmd;
  vvsc_pkg::cmd_t head_cmd;
  logic           q_not_full;
  logic           q_not_empty;
  logic           q_push;
  logic           q_pop;

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == vvsc_pkg::REG_XLEN_64);
  assign prdata    = (paddr[2] == vvsc_pkg::REG_XLEN_64) ? {31'd0, xlen_64_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xlen_64_r <= 1'b1;
    end else if (cfg_write) begin
      xlen_64_r <= pwdata[0];
    end
  end

  assign in_ready = q_not_full;
  assign q_push   = in_valid && q_not_full;

  vvsc_front #(
    .VLEN_BITS (VLEN_BITS)
  ) u_front (
    .xlen_64 (xlen_64_r),
    .in_data (in_data),
    .cmd     (front_cmd)
  );

  vvsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (front_cmd),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .head_cmd  (head_cmd),
    .not_empty (q_not_empty)
  );

  vvsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_not_empty),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: test/vset_result_checker.sv
// Result checker for the vector configuration unit: predicts vl and the decoded vtype
// for every accepted instruction and compares each result beat field by field.
// Depends on vvsc_pkg only.
module vset_result_checker #(
  parameter int VLEN_BITS = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  vvsc_pkg::in_data_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  vvsc_pkg::out_data_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  mismatches,
  output int                  results_due,
  output int                  results_seen
);

  localparam logic [2:0] XLEN_ADDR      = 3'(vvsc_pkg::REG_XLEN_64) << 2;
  localparam logic [2:0] RESERVED_VLMUL = 3'b100;

  // Shadow of the unit's architectural state
  logic        rv64_now;
  logic [7:0]  vl_now;
  logic [63:0] vtype_now;
  logic [6:0]  lmul_now;
  logic [10:0] sew_now;
  logic        vta_now;
  logic        vma_now;

  vvsc_pkg::out_data_t vset_results_q[$];

  initial begin
    mismatches   = 0;
    results_due  = 0;
    results_seen = 0;
  end

  // Execute one configuration instruction on the shadow state
  function automatic vvsc_pkg::out_data_t apply_vset(input vvsc_pkg::in_data_t ins);
    vvsc_pkg::out_data_t res;
    logic [63:0]         vt;
    logic [63:0]         avl;
    logic [63:0]         vlmax;
    logic [63:0]         vl_next;
    logic [6:0]          lmul;
    logic [2:0]          vsew;
    res = '0;
    if (ins.kind != vvsc_pkg::KIND_NONE) begin
      vt  = ins.vtype_value;
      avl = ins.avl_value;
      // RV32 sees only the low word of both operands
      if (!rv64_now) begin
        vt[63:32]  = '0;
        avl[63:32] = '0;
      end
      case (vt[2:0])
        3'b000:  lmul = 7'd8;
        3'b001:  lmul = 7'd16;
        3'b010:  lmul = 7'd32;
        3'b011:  lmul = 7'd64;
        3'b101:  lmul = 7'd1;
        3'b110:  lmul = 7'd2;
        3'b111:  lmul = 7'd4;
        default: lmul = 7'd0;
      endcase
      if (vt[2:0] == RESERVED_VLMUL) begin
        res.bad_vtype = 1'b1;
      end else begin
        vsew      = vt[5:3];
        vtype_now = vt;
        lmul_now  = lmul;
        sew_now   = 11'd8 << vsew;
        vta_now   = vt[6];
        vma_now   = vt[7];
        vlmax = (64'(VLEN_BITS) * 64'(lmul)) >> (7'd6 + 7'(vsew));
        if (ins.kind == vvsc_pkg::KIND_VSETIVLI || !ins.rs1_is_zero) begin
          vl_next = (avl < vlmax) ? avl : vlmax;
        end else if (!ins.rd_is_zero) begin
          vl_next = vlmax;
        end else begin
          vl_next = 64'(vl_now);
        end
        vl_now = vl_next[7:0];
        if (!ins.rd_is_zero) begin
          res.rd_write = 1'b1;
          res.rd_value = vl_now;
        end
      end
    end
    res.new_vl        = vl_now;
    res.lmul_eighths  = lmul_now;
    res.sew_bits      = sew_now;
    res.tail_agnostic = vta_now;
    res.mask_agnostic = vma_now;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Follow register writes, predict on input beats, compare on output beats
  always @(posedge clk) begin
    vvsc_pkg::out_data_t want;
    if (!rst_n) begin
      rv64_now  = 1'b1;
      vl_now    = '0;
      vtype_now = '0;
      lmul_now  = 7'd8;
      sew_now   = 11'd8;
      vta_now   = 1'b0;
      vma_now   = 1'b0;
      vset_results_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == XLEN_ADDR) begin
        rv64_now = pwdata[0];
      end
      if (in_valid && in_ready) begin
        vset_results_q.push_back(apply_vset(in_data));
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (vset_results_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %p", $time, out_data);
          mismatches++;
        end else begin
          want = vset_results_q.pop_front();
          check_field("rd_write", 64'(want.rd_write), 64'(out_data.rd_write));
          check_field("rd_value", 64'(want.rd_value), 64'(out_data.rd_value));
          check_field("new_vl", 64'(want.new_vl), 64'(out_data.new_vl));
          check_field("lmul_eighths", 64'(want.lmul_eighths), 64'(out_data.lmul_eighths));
          check_field("sew_bits", 64'(want.sew_bits), 64'(out_data.sew_bits));
          check_field("tail_agnostic", 64'(want.tail_agnostic),
                      64'(out_data.tail_agnostic));
          check_field("mask_agnostic", 64'(want.mask_agnostic),
                      64'(out_data.mask_agnostic));
          check_field("bad_vtype", 64'(want.bad_vtype), 64'(out_data.bad_vtype));
        end
      end
    end
    results_due <= vset_results_q.size();
  end

endmodule

FILE: test/testbench.sv
// Top of the testbench for the vector configuration unit: clock, reset, instruction
// and register stimulus, receiver stalls, watchdog and verdict.
// Depends on vvsc_pkg, vector_vset_config_unit and vset_result_checker.
module testbench;

  localparam int         VLEN_BITS   = 128;
  localparam logic [2:0] XLEN_ADDR   = 3'(vvsc_pkg::REG_XLEN_64) << 2;
  localparam int         PHASE_ITEMS = 286;
  localparam int         HOLD_CYCLES = 200;
  localparam int         STALL_LIMIT = 4000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  vvsc_pkg::in_data_t  in_data;
  logic                out_valid;
  logic                out_ready;
  vvsc_pkg::out_data_t out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int   mismatches;
  int   results_due;
  int   results_seen;
  int   sent;
  int   quiet_cycles;
  bit   gaps_on;
  bit   hold_req;
  logic xlen_plan[5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  vector_vset_config_unit #(.VLEN_BITS(VLEN_BITS)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  vset_result_checker #(.VLEN_BITS(VLEN_BITS)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .results_due (results_due),
    .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic vvsc_pkg::in_data_t make_vset(input logic [1:0] kind,
                                                   input logic [63:0] vtype,
                                                   input logic [63:0] avl, input logic rs1z,
                                                   input logic rdz);
    vvsc_pkg::in_data_t it;
    it.kind        = kind;
    it.vtype_value = vtype;
    it.avl_value   = avl;
    it.rs1_is_zero = rs1z;
    it.rd_is_zero  = rdz;
    return it;
  endfunction

  // Mostly legal vtype with some reserved vlmul and vsew; avl spread over
  // small counts, powers of two, wide values and values hiding in the low word
  function automatic vvsc_pkg::in_data_t random_vset();
    vvsc_pkg::in_data_t it;
    logic [2:0]         vlmul;
    logic [2:0]         vsew;
    logic [63:0]        avl;
    it.kind = ($urandom_range(99) < 6) ? vvsc_pkg::KIND_NONE :
              2'($urandom_range(int'(vvsc_pkg::KIND_VSETIVLI)));
    vlmul = 3'($urandom_range(7));
    vsew  = ($urandom_range(99) < 75) ? 3'($urandom_range(3)) : 3'($urandom_range(7, 4));
    it.vtype_value = {$urandom, $urandom};
    if ($urandom_range(99) < 40) begin
      it.vtype_value[63:8] = '0;
    end
    it.vtype_value[5:0] = {vsew, vlmul};
    case ($urandom_range(4))
      0:       avl = 64'($urandom_range(140));
      1:       avl = {$urandom, $urandom};
      2:       avl = {$urandom, 32'($urandom_range(140))};
      3:       avl = $urandom_range(1) ? '1 : 64'h0000_0000_FFFF_FFFF;
      default: avl = (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
    endcase
    it.avl_value   = avl;
    it.rs1_is_zero = ($urandom_range(99) < 25);
    it.rd_is_zero  = ($urandom_range(99) < 25);
    return it;
  endfunction

  // Offer one beat, with an occasional gap first; call and return at a falling edge
  task automatic send_vset(input vvsc_pkg::in_data_t it);
    if (gaps_on && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait for every expected result to leave the unit
  task automatic drain();
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= gaps_on ? ($urandom_range(99) >= 10) : 1'b1;
      end
    end
  end

  // Watchdog: end the run when no beat or register access moves for too long
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    sent     = 0;
    gaps_on  = 1'b1;
    hold_req = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: reset state, extremes, each vl rule, reserved encodings
    write_reg(XLEN_ADDR, 32'd1);
    send_vset(make_vset(vvsc_pkg::KIND_NONE, '1, '1, 1'b0, 1'b0));
    send_vset(make_vset(vvsc_pkg::KIND_VSETVLI, 64'h0, 64'h0, 1'b0, 1'b0));
    send_vset(make_vset(vvsc_pkg::KIND_VSETVLI, 64'h0, '1, 1'b0, 1'b0));
    send_vset(make_vset(vvsc_pkg::KIND_VSETVL, 64'hC3, 64'd5, 1'b1, 1'b0));
    send_vset(make_vset(vvsc_pkg::KIND_VSETVL, 64'h4, 64'd3, 1'b0, 1'b0));
    send_vset(make_vset(vvsc_pkg::KIND_VSETVLI, 64'h5, 64'd1, 1'b1, 1'b1));
    send_vset(make_vset(vvsc_pkg::KIND_NONE, 64'h0, 64'h0, 1'b1, 1'b1));
    send_vset(make_vset(vvsc_pkg::KIND_VSETIVLI, 64'h0, 64'd5, 1'b1, 1'b0));
    send_vset(make_vset(vvsc_pkg::KIND_VSETIVLI, 64'h38, 64'd31, 1'b0, 1'b0));
    send_vset(make_vset(vvsc_pkg::KIND_VSETVL, '1, '1, 1'b0, 1'b0));
    send_vset(make_vset(vvsc_pkg::KIND_VSETVL, 64'hFFFF_FFFF_FFFF_FFFC, '1, 1'b0, 1'b0));
    for (int m = 0; m < 8; m++) begin
      send_vset(make_vset(vvsc_pkg::KIND_VSETVLI, 64'({3'(m % 4), 3'(m)}), 64'd0, 1'b1,
                          1'b0));
    end
    drain();
    write_reg(XLEN_ADDR, 32'd0);
    send_vset(make_vset(vvsc_pkg::KIND_VSETVLI, 64'h0, 64'h1_0000_0000, 1'b0, 1'b0));
    send_vset(make_vset(vvsc_pkg::KIND_VSETVL, 64'hFFFF_FFFF_0000_0003,
                        64'hFFFF_FFFF_0000_0003, 1'b0, 1'b0));
    send_vset(make_vset(vvsc_pkg::KIND_VSETVL, 64'h0000_0001_0000_00C4, 64'd9, 1'b0,
                        1'b0));

    // Random phases over alternating register widths
    for (int p = 0; p < 5; p++) begin
      drain();
      write_reg(XLEN_ADDR, {31'd0, xlen_plan[p]});
      gaps_on = (p != 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == 40) begin
          hold_req = 1'b1;
        end
        send_vset(random_vset());
      end
    end

    drain();
    repeat (5) @(posedge clk);
    $display("Checked %0d results from %0d instructions over seven xlen writes,",
             results_seen, sent);
    $display("with unused kind, reserved vlmul and vsew, RV32 truncation and a long stall.");
    if (mismatches == 0 && results_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/vvsc_pkg.sv
rtl/vvsc_front.sv
rtl/vvsc_queue.sv
rtl/vvsc_back.sv
rtl/vector_vset_config_unit.sv
test/vset_result_checker.sv
test/testbench.sv
